[hdl/php_pkg.sv]
// Shared types, constants and cipher functions of the packet header protection block.
package php_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned AES_ROUNDS  = 14;
   localparam int unsigned CC_STAGES   = 40;
   localparam int unsigned PIPE_DEPTH  = CC_STAGES + 1;

   // Sample end relative to the packet-number offset: four PN bytes plus sixteen sample bytes.
   localparam logic [16:0] SAMPLE_REACH = 17'd20;
   localparam logic [7:0]  LONG_MASK    = 8'h0F;
   localparam logic [7:0]  SHORT_MASK   = 8'h1F;
   localparam logic [2:0]  PN_LEN_MAX   = 3'd4;
   localparam logic [31:0] CC_CONST0    = 32'h61707865;
   localparam logic [31:0] CC_CONST1    = 32'h3320646e;
   localparam logic [31:0] CC_CONST2    = 32'h79622d32;
   localparam logic [31:0] CC_CONST3    = 32'h6b206574;

   localparam logic CMD_PROTECT   = 1'b0;
   localparam logic CMD_UNPROTECT = 1'b1;
   localparam logic CIPHER_AES    = 1'b0;
   localparam logic CIPHER_CHACHA = 1'b1;

   typedef enum logic [2:0] {
      REG_CIPHER = 3'd0,
      REG_KEY0   = 3'd1,
      REG_KEY1   = 3'd2,
      REG_KEY2   = 3'd3,
      REG_KEY3   = 3'd4
   } php_reg_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  first_byte;
      logic [31:0] pn_bytes;
      logic [2:0]  pn_length;
      logic [63:0] sample_hi;
      logic [63:0] sample_lo;
      logic [15:0] pn_position;
      logic [15:0] packet_length;
   } php_req_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  first_byte_out;
      logic [31:0] pn_bytes_out;
      logic [2:0]  pn_length_out;
   } php_rsp_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  first_byte;
      logic [31:0] pn_bytes;
      logic [2:0]  pn_length;
      logic        ok;
   } php_item_type;

   typedef struct packed {
      php_item_type item;
      logic [127:0] sample;
   } php_entry_type;

   typedef logic [15:0][31:0] php_cc_state_type;

   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TABLE[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [31:0] bswap32(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0]   t [16];
      logic [127:0] o;
      logic [7:0]   a0, a1, a2, a3;
      int           r, c;
      for (int i = 0; i < 16; i++) begin
         r = i % 4;
         c = i / 4;
         t[i] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
      end
      for (int k = 0; k < 4; k++) begin
         a0 = t[4 * k];
         a1 = t[4 * k + 1];
         a2 = t[4 * k + 2];
         a3 = t[4 * k + 3];
         if (last) begin
            o[127 - 32 * k -: 32] = {a0, a1, a2, a3};
         end else begin
            o[127 - 32 * k -: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[127 - 32 * k - 8 -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[127 - 32 * k - 16 -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[127 - 32 * k - 24 -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end
      end
      return o ^ rk;
   endfunction

   // Half of a column or diagonal round: the first two or the last two add-xor-rotate steps.
   function automatic php_cc_state_type chacha_half(input php_cc_state_type x, input int diag,
                                                    input int second);
      php_cc_state_type y;
      int               a, b, c, d;
      y = x;
      for (int q = 0; q < 4; q++) begin
         a = q;
         b = 4 + ((q + diag) % 4);
         c = 8 + ((q + 2 * diag) % 4);
         d = 12 + ((q + 3 * diag) % 4);
         if (second == 0) begin
            y[a] = y[a] + y[b];
            y[d] = rotl32(y[d] ^ y[a], 16);
            y[c] = y[c] + y[d];
            y[b] = rotl32(y[b] ^ y[c], 12);
         end else begin
            y[a] = y[a] + y[b];
            y[d] = rotl32(y[d] ^ y[a], 8);
            y[c] = y[c] + y[d];
            y[b] = rotl32(y[b] ^ y[c], 7);
         end
      end
      return y;
   endfunction

endpackage

[hdl/php_front.sv]
// Input stage: accepts headers, runs the sample bounds check and queues them for the mask core.
module php_front import php_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  php_req_type   req,
   input  logic          pop,
   output logic          q_valid,
   output php_entry_type q_entry
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   php_entry_type      ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   php_entry_type      new_entry;

   assign req_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign push      = req_valid && req_ready;
   assign q_valid   = count_ff != '0;
   assign q_entry   = ent_ff[rd_ptr_ff];

   always_comb begin
      new_entry.item.cmd        = req.cmd;
      new_entry.item.first_byte = req.first_byte;
      new_entry.item.pn_bytes   = req.pn_bytes;
      new_entry.item.pn_length  = req.pn_length;
      new_entry.item.ok         = ({1'b0, req.pn_position} + SAMPLE_REACH) <=
                                  {1'b0, req.packet_length};
      new_entry.sample          = {req.sample_hi, req.sample_lo};
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

[hdl/php_key.sv]
// AES-256 key expansion, run once after reset and after every key register write.
module php_key import php_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [255:0]       key,
   input  logic               start,
   output logic               busy,
   output logic [14:0][127:0] round_keys
);

   logic         start_ff;
   logic         run_ff, run_in;
   logic [2:0]   step_ff, step_in;
   logic [255:0] win_ff, win_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [127:0] rk_ff [2:14];
   logic [31:0]  t, u, n0, n1, n2, n3, n4, n5, n6, n7;

   always_comb begin
      t  = sub_word({win_ff[23:0], win_ff[31:24]}) ^ {rcon_ff, 24'h000000};
      n0 = win_ff[255:224] ^ t;
      n1 = win_ff[223:192] ^ n0;
      n2 = win_ff[191:160] ^ n1;
      n3 = win_ff[159:128] ^ n2;
      u  = sub_word(n3);
      n4 = win_ff[127:96] ^ u;
      n5 = win_ff[95:64] ^ n4;
      n6 = win_ff[63:32] ^ n5;
      n7 = win_ff[31:0] ^ n6;
      if (start_ff) begin
         run_in  = 1'b1;
         step_in = 3'd1;
         win_in  = key;
         rcon_in = 8'h01;
      end else if (run_ff) begin
         run_in  = step_ff != 3'd7;
         step_in = step_ff + 3'd1;
         win_in  = {n0, n1, n2, n3, n4, n5, n6, n7};
         rcon_in = xtime(rcon_ff);
      end else begin
         run_in  = 1'b0;
         step_in = step_ff;
         win_in  = win_ff;
         rcon_in = rcon_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         run_ff   <= 1'b0;
         step_ff  <= 3'd1;
      end else begin
         start_ff <= start;
         run_ff   <= run_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      rcon_ff <= rcon_in;
      if (run_ff && !start_ff) begin
         rk_ff[{step_ff, 1'b0}] <= {n0, n1, n2, n3};
         if (step_ff != 3'd7) begin
            rk_ff[{step_ff, 1'b1}] <= {n4, n5, n6, n7};
         end
      end
   end

   always_comb begin
      round_keys[0] = key[255:128];
      round_keys[1] = key[127:0];
      for (int k = 2; k <= 14; k++) begin
         round_keys[k] = rk_ff[k];
      end
   end

   assign busy = start || start_ff || run_ff;

endmodule

[hdl/php_back.sv]
// Mask core: AES-256 and ChaCha20 pipelines, mask application and the result register.
module php_back import php_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  php_entry_type      q_entry,
   output logic               pop,
   input  logic               busy,
   input  logic               cipher,
   input  logic [255:0]       key,
   input  logic [14:0][127:0] round_keys,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output php_rsp_type        rsp
);

   logic             en;
   logic             v_ff [1:PIPE_DEPTH];
   php_item_type     side_ff [1:PIPE_DEPTH];
   php_cc_state_type cc_ff [1:CC_STAGES];
   php_cc_state_type cc_init;
   logic [127:0]     aes_ff [1:AES_ROUNDS];
   logic [39:0]      amask_ff [AES_ROUNDS+1:PIPE_DEPTH];
   logic [39:0]      cmask_ff;
   logic [31:0]      w0, w1;
   logic             rsp_valid_ff;
   php_rsp_type      rsp_ff, rsp_in;
   logic [39:0]      mask;
   php_item_type     it;
   logic [7:0]       fb;
   logic [2:0]       len;
   logic [31:0]      pn;

   assign en  = !rsp_valid_ff || rsp_ready;
   assign pop = en && q_valid && !busy;

   always_comb begin
      cc_init[0] = CC_CONST0;
      cc_init[1] = CC_CONST1;
      cc_init[2] = CC_CONST2;
      cc_init[3] = CC_CONST3;
      for (int i = 0; i < 8; i++) begin
         cc_init[4 + i] = bswap32(key[255 - 32 * i -: 32]);
      end
      for (int i = 0; i < 4; i++) begin
         cc_init[12 + i] = bswap32(q_entry.sample[127 - 32 * i -: 32]);
      end
      w0 = cc_ff[CC_STAGES][0] + CC_CONST0;
      w1 = cc_ff[CC_STAGES][1] + CC_CONST1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= PIPE_DEPTH; k++) begin
            v_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[1] <= pop;
         for (int k = 2; k <= PIPE_DEPTH; k++) begin
            v_ff[k] <= v_ff[k - 1];
         end
         rsp_valid_ff <= v_ff[PIPE_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= q_entry.item;
         for (int k = 2; k <= PIPE_DEPTH; k++) begin
            side_ff[k] <= side_ff[k - 1];
         end
         cc_ff[1] <= chacha_half(cc_init, 0, 0);
         for (int k = 2; k <= CC_STAGES; k++) begin
            cc_ff[k] <= chacha_half(cc_ff[k - 1], ((k - 1) / 2) % 2, (k - 1) % 2);
         end
         cmask_ff <= {w0[7:0], w0[15:8], w0[23:16], w0[31:24], w1[7:0]};
         aes_ff[1] <= aes_round(q_entry.sample ^ round_keys[0], round_keys[1], 1'b0);
         for (int k = 2; k <= AES_ROUNDS; k++) begin
            aes_ff[k] <= aes_round(aes_ff[k - 1], round_keys[k], k == AES_ROUNDS);
         end
         amask_ff[AES_ROUNDS + 1] <= aes_ff[AES_ROUNDS][127:88];
         for (int k = AES_ROUNDS + 2; k <= PIPE_DEPTH; k++) begin
            amask_ff[k] <= amask_ff[k - 1];
         end
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      mask = (cipher == CIPHER_CHACHA) ? cmask_ff : amask_ff[PIPE_DEPTH];
      it   = side_ff[PIPE_DEPTH];
      fb   = it.first_byte ^ (mask[39:32] & (it.first_byte[7] ? LONG_MASK : SHORT_MASK));
      if (it.cmd == CMD_UNPROTECT) begin
         len = {1'b0, fb[1:0]} + 3'd1;
      end else begin
         len = (it.pn_length > PN_LEN_MAX) ? PN_LEN_MAX : it.pn_length;
      end
      pn = it.pn_bytes;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < len) begin
            pn[31 - 8 * i -: 8] = pn[31 - 8 * i -: 8] ^ mask[31 - 8 * i -: 8];
         end
      end
      if (it.ok) begin
         rsp_in = '{ok: 1'b1, first_byte_out: fb, pn_bytes_out: pn, pn_length_out: len};
      end else begin
         rsp_in = '{ok: 1'b0, first_byte_out: it.first_byte, pn_bytes_out: it.pn_bytes,
                    pn_length_out: 3'd0};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[hdl/packet_header_protection.sv]
// Packet header protection: one transfer per cycle while responses are taken and no key
// expansion runs. The ChaCha20 path sets the depth: 40 half-round stages plus the final add;
// AES-256 is padded. A request waits in the input queue, then passes through the pipeline to
// the response register. After reset and each key write the AES key expansion holds off new work.
// Reset is synchronous; it empties the queue and pipeline, clears the configuration registers
// and starts the key expansion.
module packet_header_protection import php_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  php_req_type req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output php_rsp_type rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   logic               cipher_ff;
   logic [63:0]        key_ff [4];
   logic               wr;
   logic               key_wr;
   logic [2:0]         idx;
   logic               pop;
   logic               q_valid;
   php_entry_type      q_entry;
   logic               busy;
   logic [255:0]       key;
   logic [14:0][127:0] round_keys;

   assign pready = 1'b1;
   assign idx    = paddr[5:3];
   assign wr     = psel && penable && pwrite;
   assign key    = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
   assign key_wr = wr && (idx == REG_KEY0 || idx == REG_KEY1 || idx == REG_KEY2 ||
                          idx == REG_KEY3);

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_ff <= CIPHER_AES;
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
      end else if (wr) begin
         case (idx)
            REG_CIPHER: cipher_ff <= pwdata[0];
            REG_KEY0:   key_ff[0] <= pwdata;
            REG_KEY1:   key_ff[1] <= pwdata;
            REG_KEY2:   key_ff[2] <= pwdata;
            REG_KEY3:   key_ff[3] <= pwdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_CIPHER: prdata = {63'd0, cipher_ff};
         REG_KEY0:   prdata = key_ff[0];
         REG_KEY1:   prdata = key_ff[1];
         REG_KEY2:   prdata = key_ff[2];
         REG_KEY3:   prdata = key_ff[3];
         default:    prdata = '0;
      endcase
   end

   php_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_entry   (q_entry)
   );

   php_key u_key (
      .clock      (clock),
      .reset      (reset),
      .key        (key),
      .start      (key_wr),
      .busy       (busy),
      .round_keys (round_keys)
   );

   php_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop),
      .busy       (busy),
      .cipher     (cipher_ff),
      .key        (key),
      .round_keys (round_keys),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

endmodule

[hdl/php_checker.sv]
// Port-level checks of the packet header protection block and their binding.
module php_checker import php_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input php_rsp_type rsp,
   input logic        pready
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_fail_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.ok |-> rsp.pn_length_out == 3'd0)
      else $error("failed transfer reports a packet-number length");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.pn_length_out <= PN_LEN_MAX)
      else $error("packet-number length out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");

endmodule

bind packet_header_protection php_checker u_php_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp),
   .pready    (pready)
);
